// File: rtl/core/vigenere_cipher_stream_macros.svh
`ifndef VIGENERE_CIPHER_STREAM_MACROS_SVH
`define VIGENERE_CIPHER_STREAM_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while rst is high.
`define VCS_ASSERT_IMP(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) else $error(msg);

// Next-cycle implication, checked on clk and disabled while rst is high.
`define VCS_ASSERT_NEXT(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) else $error(msg);

`endif

// File: rtl/core/vcs_pkg.sv
`timescale 1ns / 1ps

package vcs_pkg;

  localparam int KEY_DEPTH = 16;
  localparam int POS_W = $clog2(KEY_DEPTH);
  localparam int LEN_W = POS_W + 1;
  localparam int ALPHA_SIZE = 63;

  localparam logic [1:0] REG_KEY_LOW = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd2;
  localparam logic [1:0] REG_DIRECTION = 2'd3;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       msg_ok;
    logic [5:0] msg_idx;
    logic       key_ok;
    logic [5:0] key_idx;
  } vcs_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } vcs_q_status_t;

  // Returns {in_alphabet, index}.
  function automatic logic [6:0] sym_index(input logic [7:0] b);
    logic [7:0] d;
    logic [6:0] r;
    d = 8'd0;
    r = 7'd0;
    if (b >= 8'h61 && b <= 8'h7a) begin
      d = b - 8'h61;
      r = {1'b1, d[5:0]};
    end else if (b >= 8'h41 && b <= 8'h5a) begin
      d = b - 8'h41 + 8'd26;
      r = {1'b1, d[5:0]};
    end else if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30 + 8'd52;
      r = {1'b1, d[5:0]};
    end else if (b == 8'h20) begin
      r = {1'b1, 6'd62};
    end
    return r;
  endfunction

  function automatic logic [7:0] sym_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'h61 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = 8'd39 + {2'b00, idx};
    end else if (idx < 6'd62) begin
      c = {2'b00, idx} - 8'd4;
    end else begin
      c = 8'h20;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/vcs_front.sv
`timescale 1ns / 1ps

module vcs_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [7:0]               char_in,
  input  logic                     message_start,
  input  logic [63:0]              key_low,
  input  logic [63:0]              key_high,
  input  logic [vcs_pkg::LEN_W-1:0] key_length,
  input  vcs_pkg::vcs_q_status_t   q_status,
  output logic                     push,
  output vcs_pkg::vcs_item_t       push_item
);

  logic [vcs_pkg::POS_W-1:0] key_position;
  logic [vcs_pkg::POS_W-1:0] key_position_next;
  logic [vcs_pkg::LEN_W-1:0] len;
  logic [vcs_pkg::LEN_W-1:0] pos;
  logic [vcs_pkg::LEN_W-1:0] pos_inc;
  logic [127:0]              key_all;
  logic [7:0]                key_char;
  logic [6:0]                msg_sym;
  logic [6:0]                key_sym;

  assign item_stall = q_status.full;
  assign push = item_valid && !q_status.full;
  assign key_all = {key_high, key_low};

  always_comb begin
    len = key_length;
    if (len == '0) begin
      len = vcs_pkg::LEN_W'(1);
    end else if (len > vcs_pkg::LEN_W'(vcs_pkg::KEY_DEPTH)) begin
      len = vcs_pkg::LEN_W'(vcs_pkg::KEY_DEPTH);
    end
    pos = message_start ? '0 : {1'b0, key_position};
    if (pos >= len) begin
      pos = '0;
    end
    pos_inc = pos + vcs_pkg::LEN_W'(1);
    if (pos_inc >= len) begin
      pos_inc = '0;
    end
    key_position_next = pos_inc[vcs_pkg::POS_W-1:0];
    key_char = key_all[pos[vcs_pkg::POS_W-1:0]*8 +: 8];
    msg_sym = vcs_pkg::sym_index(char_in);
    key_sym = vcs_pkg::sym_index(key_char);
    push_item.char_in = char_in;
    push_item.msg_ok = msg_sym[6];
    push_item.msg_idx = msg_sym[5:0];
    push_item.key_ok = key_sym[6];
    push_item.key_idx = key_sym[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_position <= '0;
    end else if (push) begin
      key_position <= key_position_next;
    end
  end

endmodule

// File: rtl/core/vcs_queue.sv
`timescale 1ns / 1ps

module vcs_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  vcs_pkg::vcs_item_t     push_item,
  input  logic                   pop,
  output vcs_pkg::vcs_item_t     pop_item,
  output vcs_pkg::vcs_q_status_t status
);

  vcs_pkg::vcs_item_t entries [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         count;

  assign status.full = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: rtl/core/vcs_back.sv
`timescale 1ns / 1ps

module vcs_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   direction,
  input  vcs_pkg::vcs_q_status_t q_status,
  input  vcs_pkg::vcs_item_t     item,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [7:0]             char_out
);

  logic [6:0] sum;
  logic [6:0] wrapped;
  logic [5:0] idx;
  logic [7:0] char_out_next;

  assign pop = !q_status.empty && (!result_valid || !result_stall);

  always_comb begin
    if (direction == vcs_pkg::DIR_DECRYPT) begin
      sum = {1'b0, item.msg_idx} + 7'(vcs_pkg::ALPHA_SIZE) - {1'b0, item.key_idx};
    end else begin
      sum = {1'b0, item.msg_idx} + {1'b0, item.key_idx};
    end
    wrapped = (sum >= 7'(vcs_pkg::ALPHA_SIZE)) ? sum - 7'(vcs_pkg::ALPHA_SIZE) : sum;
    idx = wrapped[5:0];
    if (!item.key_ok) begin
      if (direction == vcs_pkg::DIR_DECRYPT) begin
        idx = (item.msg_idx == 6'd62) ? 6'd0 : item.msg_idx + 6'd1;
      end else begin
        idx = (item.msg_idx == 6'd0) ? 6'd15 : item.msg_idx - 6'd1;
      end
    end
    char_out_next = item.msg_ok ? vcs_pkg::sym_char(idx) : item.char_in;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_out <= char_out_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/vigenere_cipher_stream.sv
`timescale 1ns / 1ps
`include "vigenere_cipher_stream_macros.svh"

// Vigenere cipher over a 63-symbol alphabet (a-z, A-Z, 0-9, space), one byte
// per transfer. Each accepted byte yields exactly one result byte, in order.
// It sustains one transfer per cycle on both channels while result_stall is low;
// each accepted byte passes through the queue into registered char_out and result_valid.
// A two-entry queue between the classifying front end and the cipher back end sets the
// input stall: item_stall rises only when the queue is full. The user is to write key and
// mode registers through the cfg port only while no byte is in flight; not enforced here.
module vigenere_cipher_stream (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [7:0]  char_in,
  input  logic        message_start,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  char_out
);

  logic [63:0]               key_low;
  logic [63:0]               key_high;
  logic [vcs_pkg::LEN_W-1:0] key_length;
  logic                      direction;
  logic                      push;
  logic                      pop;
  vcs_pkg::vcs_item_t        push_item;
  vcs_pkg::vcs_item_t        pop_item;
  vcs_pkg::vcs_q_status_t    q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low <= '0;
      key_high <= '0;
      key_length <= vcs_pkg::LEN_W'(1);
      direction <= vcs_pkg::DIR_ENCRYPT;
    end else if (cfg_write) begin
      case (cfg_index)
        vcs_pkg::REG_KEY_LOW: key_low <= cfg_data;
        vcs_pkg::REG_KEY_HIGH: key_high <= cfg_data;
        vcs_pkg::REG_KEY_LENGTH: key_length <= cfg_data[vcs_pkg::LEN_W-1:0];
        vcs_pkg::REG_DIRECTION: direction <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  vcs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .char_in       (char_in),
    .message_start (message_start),
    .key_low       (key_low),
    .key_high      (key_high),
    .key_length    (key_length),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  vcs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  vcs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .direction    (direction),
    .q_status     (q_status),
    .item         (pop_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .char_out     (char_out)
  );

  `VCS_ASSERT_IMP(a_queue_status, 1'b1, !(q_status.full && q_status.empty), "queue full and empty")
  `VCS_ASSERT_NEXT(a_accept_fills, item_valid && !item_stall, !q_status.empty, "accepted byte lost")
  `VCS_ASSERT_NEXT(a_no_phantom, result_valid && !result_stall && q_status.empty, !result_valid, "result without byte")

endmodule

// File: bench/vigenere_cipher_stream_tb.sv
`timescale 1ns / 1ps

module vigenere_cipher_stream_tb;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 250;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 200;
  localparam int MAX_PRINTED = 40;

  class cipher_scoreboard;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [4:0]  key_len;
    logic        dir;
    int unsigned key_pos;
    logic [7:0]  expected_chars[$];

    function new();
      key_low = 64'd0;
      key_high = 64'd0;
      key_len = 5'd1;
      dir = vcs_pkg::DIR_ENCRYPT;
      key_pos = 0;
    endfunction

    function int symbol_code(logic [7:0] b);
      if (b >= "a" && b <= "z") return int'(b) - int'("a");
      if (b >= "A" && b <= "Z") return int'(b) - int'("A") + 26;
      if (b >= "0" && b <= "9") return int'(b) - int'("0") + 52;
      if (b == " ") return 62;
      return -1;
    endfunction

    function logic [7:0] symbol_byte(int n);
      if (n < 26) return 8'(int'("a") + n);
      if (n < 52) return 8'(int'("A") + n - 26);
      if (n < 62) return 8'(int'("0") + n - 52);
      return " ";
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        vcs_pkg::REG_KEY_LOW: key_low = data;
        vcs_pkg::REG_KEY_HIGH: key_high = data;
        vcs_pkg::REG_KEY_LENGTH: key_len = data[4:0];
        vcs_pkg::REG_DIRECTION: dir = data[0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] c, logic start);
      int unsigned len;
      int unsigned pos;
      int m;
      int k;
      int n;
      logic [7:0] kc;
      logic [7:0] res;
      len = key_len;
      if (len == 0) len = 1;
      if (len > vcs_pkg::KEY_DEPTH) len = vcs_pkg::KEY_DEPTH;
      pos = start ? 0 : key_pos;
      if (pos >= len) pos = 0;
      res = c;
      m = symbol_code(c);
      if (m >= 0) begin
        kc = (pos < 8) ? key_low[pos * 8 +: 8] : key_high[(pos - 8) * 8 +: 8];
        k = symbol_code(kc);
        if (dir == vcs_pkg::DIR_DECRYPT) begin
          n = (k < 0) ? (m + 1) % vcs_pkg::ALPHA_SIZE
                      : (m + vcs_pkg::ALPHA_SIZE - k) % vcs_pkg::ALPHA_SIZE;
        end else begin
          n = (k < 0) ? ((m == 0) ? 15 : m - 1) : (m + k) % vcs_pkg::ALPHA_SIZE;
        end
        res = symbol_byte(n);
      end
      pos = pos + 1;
      if (pos >= len) pos = 0;
      key_pos = pos;
      expected_chars.push_back(res);
    endfunction

    function bit check_byte(logic [7:0] got, output string why);
      logic [7:0] want;
      why = "";
      if (expected_chars.size() == 0) begin
        why = $sformatf("char_out 0x%02h with no transfer pending", got);
        return 1'b0;
      end
      want = expected_chars.pop_front();
      if (got !== want) begin
        why = $sformatf("char_out 0x%02h, expected 0x%02h", got, want);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = vcs_pkg::REG_KEY_LOW;
  logic [63:0] cfg_data = 64'd0;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [7:0]  char_in = 8'h00;
  logic        message_start = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  char_out;

  cipher_scoreboard sb = new();
  int error_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int seg_left = 0;
  int seg_mode = 0;

  vigenere_cipher_stream u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .char_in(char_in),
    .message_start(message_start),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .char_out(char_out)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTED) $display("tb: mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic send_byte(input logic [7:0] c, input logic start);
    item_valid <= 1'b1;
    char_in <= c;
    message_start <= start;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_byte(c, start);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_char();
    if ($urandom_range(0, 9) < 7) return sb.symbol_byte($urandom_range(0, 62));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [63:0] rand_key_word();
    logic [63:0] w;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      w[i * 8 +: 8] = ($urandom_range(0, 19) < 17) ? sb.symbol_byte($urandom_range(0, 62))
                                                    : 8'($urandom_range(0, 255));
    end
    return w;
  endfunction

  function automatic logic [63:0] rand_length();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'd16;
      3: return 64'($urandom_range(17, 30));
      4: return 64'd31;
      default: return 64'($urandom_range(1, 16));
    endcase
  endfunction

  always @(posedge clk) begin
    string why;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (!sb.check_byte(char_out, why)) report_error(why);
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        result_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(5, 60);
        end
        seg_left--;
        case (seg_mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= (seg_left % 3 == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    int phase_items;
    int msg_len;
    bit noisy;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key bytes are all zero, so every key character is outside the alphabet.
    send_byte("a", 1'b1);
    send_byte("b", 1'b0);
    send_byte("Z", 1'b0);
    send_byte(" ", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    drain();
    write_reg(vcs_pkg::REG_DIRECTION, {63'd0, vcs_pkg::DIR_DECRYPT});
    send_byte(" ", 1'b1);
    send_byte("a", 1'b0);
    send_byte("9", 1'b0);
    drain();
    write_reg(vcs_pkg::REG_KEY_LOW, 64'h4d01_3071_2039_5a61);
    write_reg(vcs_pkg::REG_KEY_HIGH, 64'h207a_6130_3941_c37a);
    write_reg(vcs_pkg::REG_KEY_LENGTH, 64'd31);
    write_reg(vcs_pkg::REG_DIRECTION, {63'd0, vcs_pkg::DIR_ENCRYPT});
    send_byte("z", 1'b1);
    send_byte("Z", 1'b0);
    send_byte("9", 1'b0);
    send_byte(" ", 1'b0);
    send_byte("a", 1'b0);
    send_byte("A", 1'b0);
    send_byte("0", 1'b0);
    send_byte("m", 1'b0);
    send_byte("!", 1'b0);
    send_byte("x", 1'b0);
    drain();
    // The key position is now past the new length, so key character 0 applies.
    write_reg(vcs_pkg::REG_KEY_LENGTH, 64'd4);
    send_byte("a", 1'b0);
    drain();
    write_reg(vcs_pkg::REG_KEY_LENGTH, 64'd0);
    send_byte("b", 1'b0);
    send_byte("c", 1'b0);
    drain();

    hold_req = 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(vcs_pkg::REG_KEY_LOW, rand_key_word());
      write_reg(vcs_pkg::REG_KEY_HIGH, rand_key_word());
      write_reg(vcs_pkg::REG_KEY_LENGTH, rand_length());
      write_reg(vcs_pkg::REG_DIRECTION, {63'd0, 1'($urandom_range(0, 1))});
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        msg_len = $urandom_range(1, 40);
        noisy = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < msg_len; i++) begin
          pace();
          if (noisy) begin
            send_byte(rand_char(), 1'($urandom_range(0, 1)));
          end else if (i == 0) begin
            send_byte(rand_char(), !(phase_items == 0 && $urandom_range(0, 4) == 0));
          end else begin
            send_byte(rand_char(), 1'b0);
          end
          phase_items++;
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/vcs_pkg.sv
rtl/core/vcs_front.sv
rtl/core/vcs_queue.sv
rtl/core/vcs_back.sv
rtl/core/vigenere_cipher_stream.sv
bench/vigenere_cipher_stream_tb.sv
